// ===== hdl/mm3h_pkg.sv =====
// Shared types and constants for the MurmurHash3 x86_32 key hasher.
// No dependencies; imported by the controller, the datapath and the top level.
package mm3h_pkg;

  localparam logic [31:0] MIX_C1     = 32'hcc9e2d51;
  localparam logic [31:0] MIX_C2     = 32'h1b873593;
  localparam logic [31:0] MIX_ADD    = 32'he6546b64;
  localparam logic [31:0] FIN_C1     = 32'h85ebca6b;
  localparam logic [31:0] FIN_C2     = 32'hc2b2ae35;
  localparam logic [31:0] SEED_RESET = 32'd1374629187;
  localparam logic [2:0]  FULL_BYTES = 3'd4;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCR1,
    ST_SCR2,
    ST_MIX,
    ST_FIN1,
    ST_FIN2,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic load;
    logic scr1;
    logic scr2;
    logic mix;
    logic fin1;
    logic fin2;
    logic emit;
  } dp_cmd_t;

  typedef struct packed {
    logic last;
    logic out_free;
  } dp_stat_t;

  function automatic logic [31:0] mask_bytes(input logic [31:0] w, input logic [2:0] nb);
    logic [31:0] m;
    case (nb)
      3'd0:    m = 32'h0000_0000;
      3'd1:    m = 32'h0000_00ff;
      3'd2:    m = 32'h0000_ffff;
      3'd3:    m = 32'h00ff_ffff;
      default: m = 32'hffff_ffff;
    endcase
    return w & m;
  endfunction

endpackage

// ===== hdl/mm3h_dp.sv =====
// Datapath of the key hasher: seed register, word scrambling, running hash,
// length counter, finaliser and output register. Depends on mm3h_pkg.
module mm3h_dp (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            cfg_wr_en,
  input  logic [31:0]     cfg_wr_data,
  input  logic [31:0]     in_key_word,
  input  logic [2:0]      in_valid_bytes,
  input  logic            in_last_word,
  input  logic            out_ready,
  output logic            out_valid,
  output logic [31:0]     out_hash_value,
  input  mm3h_pkg::dp_cmd_t  cmd,
  output mm3h_pkg::dp_stat_t stat
);
  import mm3h_pkg::*;

  logic [31:0] seed_r;
  logic [31:0] h_r, h_nxt;
  logic [31:0] len_r, len_nxt;
  logic [31:0] k_r, k_nxt;
  logic [31:0] f_r, f_nxt;
  logic [2:0]  nb_r, nb_nxt;
  logic        last_r, last_nxt;
  logic        open_r, open_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic [31:0] out_hash_r, out_hash_nxt;
  logic [2:0]  nb_eff;
  logic [31:0] hx, hrot, tfin, fsh;

  assign nb_eff = (!in_last_word || (in_valid_bytes > FULL_BYTES)) ? FULL_BYTES
                                                                   : in_valid_bytes;
  assign hx   = h_r ^ k_r;
  assign hrot = {hx[18:0], hx[31:19]};
  assign tfin = h_r ^ len_r;
  assign fsh  = f_r ^ {13'd0, f_r[31:13]};

  always_comb begin
    h_nxt         = h_r;
    len_nxt       = len_r;
    k_nxt         = k_r;
    f_nxt         = f_r;
    nb_nxt        = nb_r;
    last_nxt      = last_r;
    open_nxt      = open_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_hash_nxt  = out_hash_r;
    if (cmd.load) begin
      k_nxt    = mask_bytes(in_key_word, nb_eff);
      nb_nxt   = nb_eff;
      last_nxt = in_last_word;
      open_nxt = 1'b1;
      if (!open_r) begin
        h_nxt   = seed_r;
        len_nxt = 32'd0;
      end
    end
    if (cmd.scr1) begin
      k_nxt = k_r * MIX_C1;
    end
    if (cmd.scr2) begin
      k_nxt = {k_r[16:0], k_r[31:17]} * MIX_C2;
    end
    if (cmd.mix) begin
      len_nxt = len_r + {29'd0, nb_r};
      if (nb_r == FULL_BYTES) begin
        h_nxt = {hrot[29:0], 2'b00} + hrot + MIX_ADD;
      end else begin
        h_nxt = hx;
      end
      if (last_r) begin
        open_nxt = 1'b0;
      end
    end
    if (cmd.fin1) begin
      f_nxt = (tfin ^ {16'd0, tfin[31:16]}) * FIN_C1;
    end
    if (cmd.fin2) begin
      f_nxt = fsh * FIN_C2;
    end
    if (cmd.emit) begin
      out_valid_nxt = 1'b1;
      out_hash_nxt  = f_r ^ {16'd0, f_r[31:16]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_r      <= SEED_RESET;
      open_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        seed_r <= cfg_wr_data;
      end
      open_r      <= open_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    h_r        <= h_nxt;
    len_r      <= len_nxt;
    k_r        <= k_nxt;
    f_r        <= f_nxt;
    nb_r       <= nb_nxt;
    last_r     <= last_nxt;
    out_hash_r <= out_hash_nxt;
  end

  assign stat.last      = last_r;
  assign stat.out_free  = !out_valid_r || out_ready;
  assign out_valid      = out_valid_r;
  assign out_hash_value = out_hash_r;

  a_emit_needs_slot: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> (!out_valid_r || out_ready))
    else $error("result loaded over an unconsumed result");

  a_emit_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |=> out_valid_r)
    else $error("result not presented after emit");

  a_mix_last_closes: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.mix && last_r) |=> !open_r)
    else $error("key left open after its last word");

endmodule

// ===== hdl/mm3h_ctrl.sv =====
// Controller of the key hasher: sequences scrambling, mixing and finalising
// of one request at a time. Depends on mm3h_pkg.
module mm3h_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  output mm3h_pkg::dp_cmd_t  cmd,
  input  mm3h_pkg::dp_stat_t stat
);
  import mm3h_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_SCR1;
        end
      end
      ST_SCR1: begin
        cmd.scr1  = 1'b1;
        state_nxt = ST_SCR2;
      end
      ST_SCR2: begin
        cmd.scr2  = 1'b1;
        state_nxt = ST_MIX;
      end
      ST_MIX: begin
        cmd.mix   = 1'b1;
        state_nxt = stat.last ? ST_FIN1 : ST_IDLE;
      end
      ST_FIN1: begin
        cmd.fin1  = 1'b1;
        state_nxt = ST_FIN2;
      end
      ST_FIN2: begin
        cmd.fin2  = 1'b1;
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (stat.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r == ST_SCR1))
    else $error("accepted request did not start scrambling");

  a_last_finalises: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_MIX && stat.last) |=> (state_r == ST_FIN1))
    else $error("last word did not enter finalisation");

  a_emit_waits: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EMIT && !stat.out_free) |=> (state_r == ST_EMIT))
    else $error("result dropped while the output was occupied");

endmodule

// ===== hdl/murmur3_32_key_hash_top.sv =====
// Top level of the MurmurHash3 x86_32 key hasher.
// Instantiates mm3h_ctrl and mm3h_dp; depends on mm3h_pkg.
//
// A key is sent as a series of input requests, one little-endian 32-bit word
// each, the first key byte in bits 7:0. Words that are not the last count as
// four bytes. The last word, marked by in_last_word, carries 0 to 4 valid low
// bytes (5 to 7 count as 4) and yields one 32-bit hash on the output channel.
// The seed is written through cfg_wr_en and cfg_wr_data, and the user must do
// so only while the block is idle, as the block itself does not enforce it;
// it is taken when the first word of a key is accepted. A word is accepted
// only when the previous one has passed its scramble and hash update: the
// scramble holds two registered 32-bit multiplies followed by the hash update,
// all on one shared sequence. For a last word the finaliser adds two more
// multiplies and an output load, and the next word waits for that load.
// The result sits in an output register, so the next key may be accepted while
// a hash waits; if the receiver stalls, finalisation of a following key pauses
// until the register is free. Reset restores the seed to its default value,
// empties the output register and starts a fresh key.
module murmur3_32_key_hash_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [31:0] cfg_wr_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] in_key_word,
  input  logic [2:0]  in_valid_bytes,
  input  logic        in_last_word,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_hash_value
);
  import mm3h_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  mm3h_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .cmd      (cmd),
    .stat     (stat)
  );

  mm3h_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .in_key_word    (in_key_word),
    .in_valid_bytes (in_valid_bytes),
    .in_last_word   (in_last_word),
    .out_ready      (out_ready),
    .out_valid      (out_valid),
    .out_hash_value (out_hash_value),
    .cmd            (cmd),
    .stat           (stat)
  );

endmodule

// ===== bench/murmur3_32_key_hash_tb.sv =====
// Self-checking testbench for the MurmurHash3 x86_32 key hasher.
// Keys go in as random and directed word requests and each returned hash is
// compared with a software hash kept in step; depends on mm3h_pkg.
`timescale 1ns / 100ps

module testbench;

  import mm3h_pkg::*;

  localparam int unsigned SETTLE_CYCLES = 12;
  localparam int unsigned SEGMENTS      = 10;
  localparam int unsigned SEGMENT_WORDS = 103;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        cfg_wr_en;
  logic [31:0] cfg_wr_data;
  logic        in_valid;
  logic        in_ready;
  logic [31:0] in_key_word;
  logic [2:0]  in_valid_bytes;
  logic        in_last_word;
  logic        out_valid;
  logic        out_ready;
  logic [31:0] out_hash_value;

  logic [31:0] seed_now;
  logic [31:0] run_hash;
  logic [31:0] run_len;
  logic        key_in_progress;
  logic [31:0] expected_hashes[$];

  int unsigned max_in_gap;
  int unsigned max_out_stall;
  int unsigned ready_wait;
  int unsigned words_sent;
  int unsigned mismatches;

  murmur3_32_key_hash_top i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_key_word    (in_key_word),
    .in_valid_bytes (in_valid_bytes),
    .in_last_word   (in_last_word),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_hash_value (out_hash_value)
  );

  always #5 clk = ~clk;

  function automatic logic [31:0] rotate_left(input logic [31:0] v, input int unsigned r);
    return (v << r) | (v >> (32 - r));
  endfunction

  function automatic logic [31:0] scramble_block(input logic [31:0] k);
    logic [31:0] t;
    t = k * 32'hcc9e2d51;
    t = rotate_left(t, 15);
    t = t * 32'h1b873593;
    return t;
  endfunction

  function automatic logic [31:0] absorb_block(input logic [31:0] h, input logic [31:0] k);
    logic [31:0] t;
    t = h ^ scramble_block(k);
    t = rotate_left(t, 13);
    return t * 32'd5 + 32'he6546b64;
  endfunction

  function automatic logic [31:0] avalanche(input logic [31:0] h);
    logic [31:0] t;
    t = h ^ (h >> 16);
    t = t * 32'h85ebca6b;
    t = t ^ (t >> 13);
    t = t * 32'hc2b2ae35;
    return t ^ (t >> 16);
  endfunction

  task automatic absorb_request(input logic [31:0] word, input logic [2:0] nbytes,
                                input logic last);
    logic [31:0] h;
    logic [31:0] len;
    logic [2:0]  nb;
    logic [31:0] keep;
    h   = key_in_progress ? run_hash : seed_now;
    len = key_in_progress ? run_len : 32'd0;
    if (!last) begin
      run_hash        = absorb_block(h, word);
      run_len         = len + 32'd4;
      key_in_progress = 1'b1;
    end else begin
      nb = (nbytes > FULL_BYTES) ? FULL_BYTES : nbytes;
      if (nb == FULL_BYTES) begin
        h = absorb_block(h, word);
      end else if (nb != 3'd0) begin
        keep = (32'd1 << (8 * nb)) - 32'd1;
        h    = h ^ scramble_block(word & keep);
      end
      len = len + 32'(nb);
      h   = h ^ len;
      expected_hashes.insert(expected_hashes.size(), avalanche(h));
      run_hash        = seed_now;
      run_len         = 32'd0;
      key_in_progress = 1'b0;
    end
  endtask

  // Result side: each returned hash is checked, then a fresh stall is drawn.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (expected_hashes.size() == 0) begin
          $error("hash_value: no hash expected, actual %h", out_hash_value);
          mismatches++;
        end else begin
          logic [31:0] want;
          want = expected_hashes.pop_front();
          if (want !== out_hash_value) begin
            $error("hash_value: expected %h, actual %h", want, out_hash_value);
            mismatches++;
          end
        end
        ready_wait = $urandom_range(0, max_out_stall);
        if (ready_wait != 0) begin
          out_ready <= 1'b0;
        end
      end else if (!out_ready) begin
        if (ready_wait == 0) begin
          out_ready <= 1'b1;
        end else begin
          ready_wait--;
        end
      end
    end
  end

  task automatic send_word(input logic [31:0] word, input logic [2:0] nbytes,
                           input logic last);
    int unsigned gap;
    gap = $urandom_range(0, max_in_gap);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_key_word    <= word;
    in_valid_bytes <= nbytes;
    in_last_word   <= last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    absorb_request(word, nbytes, last);
    words_sent++;
  endtask

  task automatic end_burst_and_drain();
    in_valid <= 1'b0;
    while (expected_hashes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_seed(input logic [31:0] value);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    seed_now = value;
    if (!key_in_progress) begin
      run_hash = value;
    end
  endtask

  function automatic logic [31:0] random_word();
    case ($urandom_range(0, 9))
      0:       return 32'h0000_0000;
      1:       return 32'hffff_ffff;
      default: return $urandom;
    endcase
  endfunction

  task automatic send_random_key();
    int unsigned n;
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 24) : $urandom_range(1, 5);
    repeat (n - 1) send_word(random_word(), 3'($urandom_range(0, 7)), 1'b0);
    send_word(random_word(), 3'($urandom_range(0, 7)), 1'b1);
  endtask

  task automatic test_tail_lengths();
    for (int nb = 0; nb < 8; nb++) begin
      send_word(32'hffff_ffff, 3'(nb), 1'b1);
    end
    send_word(32'h0000_0000, FULL_BYTES, 1'b1);
    send_word(32'h8040_2010, 3'd2, 1'b1);
    end_burst_and_drain();
  endtask

  task automatic test_multiword_keys();
    write_seed(32'h0000_0000);
    send_word(32'h0403_0201, 3'd0, 1'b0);
    send_word(32'hffff_ffff, 3'd7, 1'b0);
    send_word(32'h0000_0000, 3'd2, 1'b0);
    send_word(32'hdead_beef, 3'd3, 1'b1);
    send_word(32'hffff_ffff, 3'd1, 1'b0);
    send_word(32'hffff_ffff, 3'd0, 1'b1);
    end_burst_and_drain();
  endtask

  task automatic test_seed_extremes();
    write_seed(32'hffff_ffff);
    send_word(32'h1234_5678, 3'd0, 1'b1);
    send_word(32'h0000_0000, 3'd4, 1'b0);
    send_word(32'h5555_aaaa, 3'd1, 1'b1);
    end_burst_and_drain();
    write_seed(SEED_RESET);
    send_word(32'h0000_0061, 3'd1, 1'b1);
    end_burst_and_drain();
  endtask

  task automatic test_random_keys();
    int unsigned goal;
    for (int unsigned seg = 0; seg < SEGMENTS; seg++) begin
      case (seg % 4)
        0: begin max_in_gap = 14; max_out_stall = 14; end
        1: begin max_in_gap = 0;  max_out_stall = 0;  end
        2: begin max_in_gap = 14; max_out_stall = 0;  end
        default: begin max_in_gap = 0; max_out_stall = 14; end
      endcase
      case (seg)
        0:       write_seed(32'h0000_0000);
        1:       write_seed(32'hffff_ffff);
        2:       write_seed(SEED_RESET);
        default: write_seed($urandom);
      endcase
      goal = words_sent + SEGMENT_WORDS;
      while (words_sent < goal) send_random_key();
      end_burst_and_drain();
    end
  endtask

  initial begin
    rst_n          <= 1'b0;
    cfg_wr_en      <= 1'b0;
    cfg_wr_data    <= 32'd0;
    in_valid       <= 1'b0;
    in_key_word    <= 32'd0;
    in_valid_bytes <= 3'd0;
    in_last_word   <= 1'b0;
    out_ready      <= 1'b0;
    seed_now        = SEED_RESET;
    run_hash        = SEED_RESET;
    run_len         = 32'd0;
    key_in_progress = 1'b0;
    ready_wait      = 0;
    words_sent      = 0;
    mismatches      = 0;
    max_in_gap      = 14;
    max_out_stall   = 14;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    test_tail_lengths();
    test_multiword_keys();
    test_seed_extremes();
    test_random_keys();

    end_burst_and_drain();
    if (mismatches == 0 && expected_hashes.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
